// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the region grow RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSRG_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSRG_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/csrg_pkg.sv =====
// ----------------------------------------------------------------------------
// csrg_pkg
// Types and constants shared by the seeded region grow modules.
// ----------------------------------------------------------------------------
package csrg_pkg;

    localparam int COLOR_W = 8;
    localparam int PIX_W   = 3 * COLOR_W;
    localparam int SIZE_W  = 13;
    localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd8191;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [COLOR_W-1:0] BLUE_LIMIT_RST  = 8'd60;
    localparam logic [COLOR_W-1:0] GREEN_LIMIT_RST = 8'd50;
    localparam logic [COLOR_W-1:0] RED_LIMIT_RST   = 8'd150;

    // Command codes carried on the kind port.
    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_GROW = 2'd1,
        KIND_READ = 2'd2
    } kind_t;

    // Result codes carried on the result_kind port.
    localparam logic RES_GROW = 1'b0;
    localparam logic RES_READ = 1'b1;

    // Configuration register indexes (word address).
    typedef enum logic [1:0] {
        REG_BLUE_LIMIT  = 2'd0,
        REG_GREEN_LIMIT = 2'd1,
        REG_RED_LIMIT   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [COLOR_W-1:0] blue_limit;
        logic [COLOR_W-1:0] green_limit;
        logic [COLOR_W-1:0] red_limit;
    } limits_t;

    // Neighbor offsets, one coordinate step each.
    typedef enum logic [1:0] {
        OFF_MINUS = 2'd0,
        OFF_ZERO  = 2'd1,
        OFF_PLUS  = 2'd2
    } off_t;

    localparam off_t NB_DX [8] = '{OFF_MINUS, OFF_ZERO, OFF_PLUS,
                                   OFF_MINUS, OFF_PLUS,
                                   OFF_MINUS, OFF_ZERO, OFF_PLUS};
    localparam off_t NB_DY [8] = '{OFF_MINUS, OFF_MINUS, OFF_MINUS,
                                   OFF_ZERO, OFF_ZERO,
                                   OFF_PLUS, OFF_PLUS, OFF_PLUS};

endpackage

// ===== hw/rtl/color_seeded_region_grow.sv =====
// ----------------------------------------------------------------------------
// color_seeded_region_grow
// Seeded 8-connected region growing over a stored color image.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Handshake
//  --------  ----------------------------------------  ----------------------
//  command   kind col row blue green red               start && !busy
//  result    result_kind in_region region_size         done, one cycle
//  config    psel penable pwrite paddr pwdata prdata   APB, pready always high
//
// While the block is idle, pixel loads and mask reads are taken one per
// cycle; a read result shows up on done in the cycle after its request. A
// grow run keeps busy high while it first unmarks the previous region by
// walking the work queue, then marks the new region from the seed and
// tests the color of each region pixel; the single read port of the region
// mask memory sets the neighbor scan at one probe per cycle. After reset
// the block sweeps the whole mask memory with busy high; configuration
// writes are taken at any time. The receiver cannot stall results.
//
module color_seeded_region_grow #(
    parameter int IMAGE_WIDTH  = 64,
    parameter int IMAGE_HEIGHT = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    kind,
    input  logic [5:0]                    col,
    input  logic [5:0]                    row,
    input  logic [7:0]                    blue,
    input  logic [7:0]                    green,
    input  logic [7:0]                    red,
    output logic                          done,
    output logic                          result_kind,
    output logic                          in_region,
    output logic [12:0]                   region_size,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [csrg_pkg::APB_AW-1:0]   paddr,
    input  logic [csrg_pkg::APB_DW-1:0]   pwdata,
    output logic [csrg_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int N  = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int AW = $clog2(N);
    localparam int CW = $clog2(IMAGE_WIDTH) + $clog2(IMAGE_HEIGHT);

    csrg_pkg::limits_t limits;

    // Pixel store: 24-bit color per pixel, written by loads only.
    logic                         pix_we;
    logic [AW-1:0]                pix_waddr;
    logic [csrg_pkg::PIX_W-1:0]   pix_wdata;
    logic [AW-1:0]                pix_raddr;
    logic [csrg_pkg::PIX_W-1:0]   pix_rdata;

    // Region mask: one bit per pixel.
    logic                         mask_we;
    logic [AW-1:0]                mask_waddr;
    logic                         mask_wdata;
    logic [AW-1:0]                mask_raddr;
    logic                         mask_rdata;

    // Work queue: packed row and column of every pixel marked in the run.
    logic                         q_we;
    logic [AW-1:0]                q_waddr;
    logic [CW-1:0]                q_wdata;
    logic [AW-1:0]                q_raddr;
    logic [CW-1:0]                q_rdata;

    csrg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limits  (limits)
    );

    csrg_ram #(
        .WIDTH (csrg_pkg::PIX_W),
        .DEPTH (N)
    ) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (pix_wdata),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    csrg_ram #(
        .WIDTH (1),
        .DEPTH (N)
    ) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .waddr (mask_waddr),
        .wdata (mask_wdata),
        .raddr (mask_raddr),
        .rdata (mask_rdata)
    );

    csrg_ram #(
        .WIDTH (CW),
        .DEPTH (N)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // The sequencer owns every memory port and the result registers.
    csrg_ctrl #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .col         (col),
        .row         (row),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .limits      (limits),
        .done        (done),
        .result_kind (result_kind),
        .in_region   (in_region),
        .region_size (region_size),
        .pix_we      (pix_we),
        .pix_waddr   (pix_waddr),
        .pix_wdata   (pix_wdata),
        .pix_raddr   (pix_raddr),
        .pix_rdata   (pix_rdata),
        .mask_we     (mask_we),
        .mask_waddr  (mask_waddr),
        .mask_wdata  (mask_wdata),
        .mask_raddr  (mask_raddr),
        .mask_rdata  (mask_rdata),
        .q_we        (q_we),
        .q_waddr     (q_waddr),
        .q_wdata     (q_wdata),
        .q_raddr     (q_raddr),
        .q_rdata     (q_rdata)
    );

endmodule

// ===== hw/rtl/csrg_ram.sv =====
// ----------------------------------------------------------------------------
// csrg_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module csrg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/csrg_cfg.sv =====
// ----------------------------------------------------------------------------
// csrg_cfg
// APB register block holding the three color limits.
// ----------------------------------------------------------------------------
module csrg_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [csrg_pkg::APB_AW-1:0]    paddr,
    input  logic [csrg_pkg::APB_DW-1:0]    pwdata,
    output logic [csrg_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    output csrg_pkg::limits_t              limits
);

    logic [csrg_pkg::COLOR_W-1:0] blue_limit_reg, blue_limit_next;
    logic [csrg_pkg::COLOR_W-1:0] green_limit_reg, green_limit_next;
    logic [csrg_pkg::COLOR_W-1:0] red_limit_reg, red_limit_next;
    csrg_pkg::reg_idx_t           idx;
    logic                         wr_en;

    assign idx    = csrg_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        blue_limit_next  = blue_limit_reg;
        green_limit_next = green_limit_reg;
        red_limit_next   = red_limit_reg;
        prdata           = '0;
        unique case (idx)
            csrg_pkg::REG_BLUE_LIMIT:
            begin
                prdata = csrg_pkg::APB_DW'(blue_limit_reg);
                if (wr_en)
                begin
                    blue_limit_next = pwdata[csrg_pkg::COLOR_W-1:0];
                end
            end
            csrg_pkg::REG_GREEN_LIMIT:
            begin
                prdata = csrg_pkg::APB_DW'(green_limit_reg);
                if (wr_en)
                begin
                    green_limit_next = pwdata[csrg_pkg::COLOR_W-1:0];
                end
            end
            csrg_pkg::REG_RED_LIMIT:
            begin
                prdata = csrg_pkg::APB_DW'(red_limit_reg);
                if (wr_en)
                begin
                    red_limit_next = pwdata[csrg_pkg::COLOR_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blue_limit_reg  <= csrg_pkg::BLUE_LIMIT_RST;
            green_limit_reg <= csrg_pkg::GREEN_LIMIT_RST;
            red_limit_reg   <= csrg_pkg::RED_LIMIT_RST;
        end
        else
        begin
            blue_limit_reg  <= blue_limit_next;
            green_limit_reg <= green_limit_next;
            red_limit_reg   <= red_limit_next;
        end
    end

    assign limits.blue_limit  = blue_limit_reg;
    assign limits.green_limit = green_limit_reg;
    assign limits.red_limit   = red_limit_reg;

endmodule

// ===== hw/rtl/csrg_ctrl.sv =====
// ----------------------------------------------------------------------------
// csrg_ctrl
// Command sequencer: loads, mask reads and the queue-driven grow run.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csrg_ctrl #(
    parameter int IMAGE_WIDTH  = 64,
    parameter int IMAGE_HEIGHT = 64
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                start,
    output logic                                                busy,
    input  logic [1:0]                                          kind,
    input  logic [5:0]                                          col,
    input  logic [5:0]                                          row,
    input  logic [csrg_pkg::COLOR_W-1:0]                        blue,
    input  logic [csrg_pkg::COLOR_W-1:0]                        green,
    input  logic [csrg_pkg::COLOR_W-1:0]                        red,
    input  csrg_pkg::limits_t                                   limits,
    output logic                                                done,
    output logic                                                result_kind,
    output logic                                                in_region,
    output logic [csrg_pkg::SIZE_W-1:0]                         region_size,
    output logic                                                pix_we,
    output logic [$clog2(IMAGE_WIDTH*IMAGE_HEIGHT)-1:0]         pix_waddr,
    output logic [csrg_pkg::PIX_W-1:0]                          pix_wdata,
    output logic [$clog2(IMAGE_WIDTH*IMAGE_HEIGHT)-1:0]         pix_raddr,
    input  logic [csrg_pkg::PIX_W-1:0]                          pix_rdata,
    output logic                                                mask_we,
    output logic [$clog2(IMAGE_WIDTH*IMAGE_HEIGHT)-1:0]         mask_waddr,
    output logic                                                mask_wdata,
    output logic [$clog2(IMAGE_WIDTH*IMAGE_HEIGHT)-1:0]         mask_raddr,
    input  logic                                                mask_rdata,
    output logic                                                q_we,
    output logic [$clog2(IMAGE_WIDTH*IMAGE_HEIGHT)-1:0]         q_waddr,
    output logic [$clog2(IMAGE_WIDTH)+$clog2(IMAGE_HEIGHT)-1:0] q_wdata,
    output logic [$clog2(IMAGE_WIDTH*IMAGE_HEIGHT)-1:0]         q_raddr,
    input  logic [$clog2(IMAGE_WIDTH)+$clog2(IMAGE_HEIGHT)-1:0] q_rdata
);

    localparam int N  = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int AW = $clog2(N);
    localparam int XW = $clog2(IMAGE_WIDTH);
    localparam int YW = $clog2(IMAGE_HEIGHT);
    localparam int CW = XW + YW;
    localparam int TW = AW + 1;
    localparam int SW = csrg_pkg::SIZE_W;

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_CLEAR = 8'b0000_0100,
        S_SEED  = 8'b0000_1000,
        S_FETCH = 8'b0001_0000,
        S_PIXEL = 8'b0010_0000,
        S_TEST  = 8'b0100_0000,
        S_NEIGH = 8'b1000_0000
    } state_t;

    function automatic logic [AW-1:0] coord_addr(input logic [XW-1:0] x,
                                                  input logic [YW-1:0] y);
        coord_addr = AW'(y) * AW'(IMAGE_WIDTH) + AW'(x);
    endfunction

    function automatic logic [SW-1:0] sat_size(input logic [TW-1:0] t);
        if (32'(t) > 32'(csrg_pkg::SIZE_MAX))
        begin
            sat_size = csrg_pkg::SIZE_MAX;
        end
        else
        begin
            sat_size = SW'(t);
        end
    endfunction

    // Control state
    state_t        state_reg, state_next;
    logic [AW-1:0] init_idx_reg, init_idx_next;
    logic [TW-1:0] clr_idx_reg, clr_idx_next;
    logic          clr_vld_reg, clr_vld_next;
    logic [TW-1:0] head_reg, head_next;
    logic [TW-1:0] tail_reg, tail_next;
    logic [3:0]    nb_reg, nb_next;
    logic          p_vld_reg, p_vld_next;
    logic [SW-1:0] count_reg, count_next;
    logic          done_reg, done_next;

    // Payload
    logic [XW-1:0] cur_x_reg, cur_x_next;
    logic [YW-1:0] cur_y_reg, cur_y_next;
    logic [XW-1:0] p_x_reg, p_x_next;
    logic [YW-1:0] p_y_reg, p_y_next;
    logic [AW-1:0] p_addr_reg, p_addr_next;
    logic [XW-1:0] seed_x_reg, seed_x_next;
    logic [YW-1:0] seed_y_reg, seed_y_next;
    logic          seed_in_reg, seed_in_next;
    logic          res_kind_reg, res_kind_next;
    logic          rd_in_reg, rd_in_next;
    logic [SW-1:0] size_reg, size_next;

    // Combinational helpers
    logic [XW-1:0] cmd_x;
    logic [YW-1:0] cmd_y;
    logic          cmd_in;
    logic [AW-1:0] cmd_addr;
    logic          accept;
    logic [XW-1:0] qx;
    logic [YW-1:0] qy;
    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    logic          nx_ok;
    logic          ny_ok;
    logic [AW-1:0] n_addr;
    logic          spreads;

    assign cmd_x    = XW'(col);
    assign cmd_y    = YW'(row);
    assign cmd_in   = (32'(col) < 32'(IMAGE_WIDTH)) && (32'(row) < 32'(IMAGE_HEIGHT));
    assign cmd_addr = coord_addr(cmd_x, cmd_y);
    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && (state_reg == S_IDLE);
    assign qx       = q_rdata[XW-1:0];
    assign qy       = q_rdata[CW-1:XW];

    assign spreads = (pix_rdata[7:0] < limits.blue_limit)
                  && (pix_rdata[15:8] > limits.green_limit)
                  && (pix_rdata[23:16] > limits.red_limit);

    // Neighbor of the current pixel picked by nb_reg, clipped at the edges.
    always_comb
    begin
        nx    = cur_x_reg;
        ny    = cur_y_reg;
        nx_ok = 1'b1;
        ny_ok = 1'b1;
        case (csrg_pkg::NB_DX[nb_reg[2:0]])
            csrg_pkg::OFF_MINUS:
            begin
                nx_ok = (cur_x_reg != '0);
                nx    = cur_x_reg - XW'(1);
            end
            csrg_pkg::OFF_PLUS:
            begin
                nx_ok = (cur_x_reg != XW'(IMAGE_WIDTH - 1));
                nx    = cur_x_reg + XW'(1);
            end
            default:
            begin
                nx = cur_x_reg;
            end
        endcase
        case (csrg_pkg::NB_DY[nb_reg[2:0]])
            csrg_pkg::OFF_MINUS:
            begin
                ny_ok = (cur_y_reg != '0);
                ny    = cur_y_reg - YW'(1);
            end
            csrg_pkg::OFF_PLUS:
            begin
                ny_ok = (cur_y_reg != YW'(IMAGE_HEIGHT - 1));
                ny    = cur_y_reg + YW'(1);
            end
            default:
            begin
                ny = cur_y_reg;
            end
        endcase
    end

    assign n_addr = coord_addr(nx, ny);

    always_comb
    begin
        state_next    = state_reg;
        init_idx_next = init_idx_reg;
        clr_idx_next  = clr_idx_reg;
        clr_vld_next  = 1'b0;
        head_next     = head_reg;
        tail_next     = tail_reg;
        nb_next       = nb_reg;
        p_vld_next    = 1'b0;
        count_next    = count_reg;
        done_next     = 1'b0;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        p_x_next      = p_x_reg;
        p_y_next      = p_y_reg;
        p_addr_next   = p_addr_reg;
        seed_x_next   = seed_x_reg;
        seed_y_next   = seed_y_reg;
        seed_in_next  = seed_in_reg;
        res_kind_next = res_kind_reg;
        rd_in_next    = rd_in_reg;
        size_next     = size_reg;

        pix_we     = 1'b0;
        pix_waddr  = cmd_addr;
        pix_wdata  = {red, green, blue};
        pix_raddr  = coord_addr(qx, qy);
        mask_we    = 1'b0;
        mask_waddr = p_addr_reg;
        mask_wdata = 1'b0;
        mask_raddr = cmd_addr;
        q_we       = 1'b0;
        q_waddr    = tail_reg[AW-1:0];
        q_wdata    = {p_y_reg, p_x_reg};
        q_raddr    = head_reg[AW-1:0];

        unique case (state_reg)
            S_INIT:
            begin
                mask_we    = 1'b1;
                mask_waddr = init_idx_reg;
                mask_wdata = 1'b0;
                if (init_idx_reg == AW'(N - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_idx_next = init_idx_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                mask_raddr = cmd_addr;
                if (accept)
                begin
                    unique case (csrg_pkg::kind_t'(kind))
                        csrg_pkg::KIND_LOAD:
                        begin
                            pix_we = cmd_in;
                        end
                        csrg_pkg::KIND_GROW:
                        begin
                            seed_x_next  = cmd_x;
                            seed_y_next  = cmd_y;
                            seed_in_next = cmd_in;
                            clr_idx_next = '0;
                            state_next   = S_CLEAR;
                        end
                        csrg_pkg::KIND_READ:
                        begin
                            done_next     = 1'b1;
                            res_kind_next = csrg_pkg::RES_READ;
                            rd_in_next    = cmd_in;
                            size_next     = count_reg;
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                // Every pixel of the last region sits in the queue; unmark each.
                q_raddr = clr_idx_reg[AW-1:0];
                if (clr_idx_reg < tail_reg)
                begin
                    clr_vld_next = 1'b1;
                    clr_idx_next = clr_idx_reg + TW'(1);
                end
                if (clr_vld_reg)
                begin
                    mask_we    = 1'b1;
                    mask_waddr = coord_addr(qx, qy);
                    mask_wdata = 1'b0;
                end
                if (!(clr_idx_reg < tail_reg) && !clr_vld_reg)
                begin
                    state_next = S_SEED;
                end
            end
            S_SEED:
            begin
                head_next = '0;
                if (seed_in_reg)
                begin
                    mask_we    = 1'b1;
                    mask_waddr = coord_addr(seed_x_reg, seed_y_reg);
                    mask_wdata = 1'b1;
                    q_we       = 1'b1;
                    q_waddr    = '0;
                    q_wdata    = {seed_y_reg, seed_x_reg};
                    tail_next  = TW'(1);
                    state_next = S_FETCH;
                end
                else
                begin
                    tail_next     = '0;
                    count_next    = '0;
                    done_next     = 1'b1;
                    res_kind_next = csrg_pkg::RES_GROW;
                    size_next     = '0;
                    state_next    = S_IDLE;
                end
            end
            S_FETCH:
            begin
                q_raddr = head_reg[AW-1:0];
                if (head_reg == tail_reg)
                begin
                    count_next    = sat_size(tail_reg);
                    done_next     = 1'b1;
                    res_kind_next = csrg_pkg::RES_GROW;
                    size_next     = sat_size(tail_reg);
                    state_next    = S_IDLE;
                end
                else
                begin
                    head_next  = head_reg + TW'(1);
                    state_next = S_PIXEL;
                end
            end
            S_PIXEL:
            begin
                cur_x_next = qx;
                cur_y_next = qy;
                pix_raddr  = coord_addr(qx, qy);
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (spreads)
                begin
                    nb_next    = '0;
                    state_next = S_NEIGH;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_NEIGH:
            begin
                // Stage one looks up a neighbor, stage two marks and queues it if it is unmarked.
                if (!nb_reg[3])
                begin
                    nb_next = nb_reg + 4'd1;
                    if (nx_ok && ny_ok)
                    begin
                        mask_raddr  = n_addr;
                        p_vld_next  = 1'b1;
                        p_x_next    = nx;
                        p_y_next    = ny;
                        p_addr_next = n_addr;
                    end
                end
                if (p_vld_reg && !mask_rdata)
                begin
                    mask_we    = 1'b1;
                    mask_waddr = p_addr_reg;
                    mask_wdata = 1'b1;
                    q_we       = 1'b1;
                    q_waddr    = tail_reg[AW-1:0];
                    q_wdata    = {p_y_reg, p_x_reg};
                    tail_next  = tail_reg + TW'(1);
                end
                if (nb_reg[3] && !p_vld_reg)
                begin
                    state_next = S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            init_idx_reg <= '0;
            clr_idx_reg  <= '0;
            clr_vld_reg  <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            nb_reg       <= '0;
            p_vld_reg    <= 1'b0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            init_idx_reg <= init_idx_next;
            clr_idx_reg  <= clr_idx_next;
            clr_vld_reg  <= clr_vld_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            nb_reg       <= nb_next;
            p_vld_reg    <= p_vld_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        p_x_reg      <= p_x_next;
        p_y_reg      <= p_y_next;
        p_addr_reg   <= p_addr_next;
        seed_x_reg   <= seed_x_next;
        seed_y_reg   <= seed_y_next;
        seed_in_reg  <= seed_in_next;
        res_kind_reg <= res_kind_next;
        rd_in_reg    <= rd_in_next;
        size_reg     <= size_next;
    end

    assign done        = done_reg;
    assign result_kind = res_kind_reg;
    assign region_size = size_reg;
    assign in_region   = (res_kind_reg == csrg_pkg::RES_READ) && rd_in_reg && mask_rdata;

    `CSRG_ASSERT_NOW(a_tail_bound, clk, rst_n, 1'b1, tail_reg <= TW'(N),
        "queue tail ran past the image size")
    `CSRG_ASSERT_NOW(a_head_tail, clk, rst_n, 1'b1, head_reg <= tail_reg,
        "queue head overtook the tail")
    `CSRG_ASSERT_NEXT(a_grow_busy, clk, rst_n,
        start && !busy && kind == csrg_pkg::KIND_GROW, busy,
        "grow request did not raise busy")
    `CSRG_ASSERT_NOW(a_idle_no_mark, clk, rst_n, state_reg == S_IDLE, !mask_we,
        "region mask written while idle")
    `CSRG_ASSERT_NOW(a_probe_in_neigh, clk, rst_n, p_vld_reg, state_reg == S_NEIGH,
        "neighbor probe outside the neighbor scan")

endmodule

// ===== test/color_seeded_region_grow_test.sv =====
// ----------------------------------------------------------------------------
// color_seeded_region_grow_test
// Self-checking bench for the seeded region grow block. Requests are queued
// up front, driven through the start/busy handshake and replayed against an
// in-bench flood fill to predict each done strobe.
// ----------------------------------------------------------------------------
module color_seeded_region_grow_test;

    localparam int IMG_W = 64;
    localparam int IMG_H = 64;
    localparam int PIX_N = IMG_W * IMG_H;

    // The kind port is two bits wide; this code has no meaning and the block
    // has to drop it without a result.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct {
        logic [1:0] kind;
        logic [5:0] col;
        logic [5:0] row;
        pixel_t     color;
        bit         drain_first;
    } request_t;

    typedef struct {
        logic        result_kind;
        logic        in_region;
        logic [12:0] region_size;
    } result_t;

    // Clock, reset and every block input start at a known value.
    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    logic [1:0]  kind    = 2'd0;
    logic [5:0]  col     = 6'd0;
    logic [5:0]  row     = 6'd0;
    logic [7:0]  blue    = 8'd0;
    logic [7:0]  green   = 8'd0;
    logic [7:0]  red     = 8'd0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [csrg_pkg::APB_AW-1:0] paddr  = '0;
    logic [csrg_pkg::APB_DW-1:0] pwdata = '0;

    logic        busy;
    logic        done;
    logic        result_kind;
    logic        in_region;
    logic [12:0] region_size;
    logic [csrg_pkg::APB_DW-1:0] prdata;
    logic        pready;

    color_seeded_region_grow #(
        .IMAGE_WIDTH  (IMG_W),
        .IMAGE_HEIGHT (IMG_H)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .col         (col),
        .row         (row),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .done        (done),
        .result_kind (result_kind),
        .in_region   (in_region),
        .region_size (region_size),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shared state.
    // The color limits are only changed while the block is idle, so the
    // request generator and the predictor can both use this one copy.
    // ------------------------------------------------------------------------
    csrg_pkg::limits_t lim = '{blue_limit: csrg_pkg::BLUE_LIMIT_RST,
                               green_limit: csrg_pkg::GREEN_LIMIT_RST,
                               red_limit: csrg_pkg::RED_LIMIT_RST};

    // Predictor state: the image as the block holds it, the mask of the last
    // grow and the size that grow reported.
    pixel_t       image_pix [PIX_N];
    bit [PIX_N-1:0] region_mask = '0;
    logic [12:0]  grown_size = '0;

    // Generator state. The generator runs ahead of the block, so it keeps its
    // own picture of the image as it will be once the queued loads are in.
    // The block's pixel store is undefined until written, so every pixel a
    // grow could mark must be loaded first; plan_known tracks that.
    pixel_t       plan_pix [PIX_N];
    bit [PIX_N-1:0] plan_known = '0;
    int           plan_missing [$];

    request_t     request_q [$];
    result_t      pending_results [$];
    request_t     cur_req;
    int           idle_pct = 0;
    int           planned_items = 0;
    int           mismatch_count = 0;

    // The run limit grows with every accepted request; each grow is charged
    // more, in proportion to the sizes of the previous and the new region.
    longint       cycle_count = 0;
    longint       cycle_budget = 4 * PIX_N + 20000;

    // ------------------------------------------------------------------------
    // Prediction.
    // ------------------------------------------------------------------------
    function automatic bit passes(pixel_t px);
        return px.blue < lim.blue_limit && px.green > lim.green_limit &&
               px.red > lim.red_limit;
    endfunction

    // 8-connected flood fill from a seed. The seed is marked whatever its
    // color; only marked pixels that pass the color test mark their
    // neighbors, and neighbors off the image are skipped. When planning,
    // a marked pixel that has not been loaded yet is collected instead of
    // being tested.
    function automatic int flood(input bit planning, input int seed_x,
                                 input int seed_y);
        bit [PIX_N-1:0] seen;
        int work [$];
        int p, x, y, nx, ny, n, dx, dy, cnt;
        pixel_t px;
        seen = '0;
        p = seed_y * IMG_W + seed_x;
        seen[p] = 1'b1;
        work.push_back(p);
        cnt = 1;
        while (work.size() != 0)
        begin
            p = work.pop_front();
            x = p % IMG_W;
            y = p / IMG_W;
            if (planning && !plan_known[p])
            begin
                plan_missing.push_back(p);
                continue;
            end
            px = planning ? plan_pix[p] : image_pix[p];
            if (!passes(px))
                continue;
            for (dy = -1; dy <= 1; dy++)
            begin
                for (dx = -1; dx <= 1; dx++)
                begin
                    nx = x + dx;
                    ny = y + dy;
                    if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 &&
                        nx < IMG_W && ny < IMG_H)
                    begin
                        n = ny * IMG_W + nx;
                        if (!seen[n])
                        begin
                            seen[n] = 1'b1;
                            work.push_back(n);
                            cnt++;
                        end
                    end
                end
            end
        end
        if (!planning)
            region_mask = seen;
        return cnt;
    endfunction

    // Applies one accepted request to the predictor and queues the result
    // it should cause.
    function automatic void apply_request(request_t rq);
        int idx;
        int prev_size;
        result_t res;
        idx = int'(rq.row) * IMG_W + int'(rq.col);
        cycle_budget += 400;
        case (rq.kind)
            csrg_pkg::KIND_LOAD:
                image_pix[idx] = rq.color;
            csrg_pkg::KIND_GROW:
            begin
                prev_size = grown_size;
                grown_size = 13'(flood(1'b0, rq.col, rq.row));
                cycle_budget += 4 * (prev_size + 1 + 13 * grown_size) + 200;
                res = '{result_kind: csrg_pkg::RES_GROW, in_region: 1'b0,
                        region_size: grown_size};
                pending_results.push_back(res);
            end
            csrg_pkg::KIND_READ:
            begin
                res = '{result_kind: csrg_pkg::RES_READ, in_region: region_mask[idx],
                        region_size: grown_size};
                pending_results.push_back(res);
            end
            default:
                ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request generation.
    // ------------------------------------------------------------------------

    // A color that passes the current limits with the given chance, where
    // passing is possible at all; a negative chance gives any color.
    function automatic pixel_t make_color(int pass_pct);
        pixel_t px;
        px.blue  = 8'($urandom_range(255));
        px.green = 8'($urandom_range(255));
        px.red   = 8'($urandom_range(255));
        if (pass_pct < 0)
            return px;
        if ($urandom_range(99) < pass_pct && lim.blue_limit != 8'd0 &&
            lim.green_limit != 8'd255 && lim.red_limit != 8'd255)
        begin
            px.blue  = 8'($urandom_range(int'(lim.blue_limit) - 1, 0));
            px.green = 8'($urandom_range(255, int'(lim.green_limit) + 1));
            px.red   = 8'($urandom_range(255, int'(lim.red_limit) + 1));
        end
        else if (passes(px))
        begin
            case ($urandom_range(2))
                0: px.blue  = 8'($urandom_range(255, int'(lim.blue_limit)));
                1: px.green = 8'($urandom_range(int'(lim.green_limit), 0));
                default: px.red = 8'($urandom_range(int'(lim.red_limit), 0));
            endcase
        end
        return px;
    endfunction

    function automatic void add_request(logic [1:0] k, int c, int r,
                                        pixel_t px, bit drain);
        request_t rq;
        rq.kind = k;
        rq.col = 6'(c);
        rq.row = 6'(r);
        rq.color = px;
        rq.drain_first = drain;
        request_q.push_back(rq);
        if (k == csrg_pkg::KIND_LOAD)
        begin
            plan_pix[r * IMG_W + c] = px;
            plan_known[r * IMG_W + c] = 1'b1;
        end
        if (k != KIND_SPARE)
            planned_items++;
    endfunction

    // Queues a grow, first loading every pixel the grow would touch that has
    // never been written. Filled pixels pass with the given chance, so a low
    // chance keeps the region from running away across the image.
    function automatic void add_grow(int c, int r, int fill_pct);
        do
        begin
            plan_missing.delete();
            void'(flood(1'b1, c, r));
            foreach (plan_missing[i])
                add_request(csrg_pkg::KIND_LOAD, plan_missing[i] % IMG_W,
                            plan_missing[i] / IMG_W, make_color(fill_pct),
                            $urandom_range(99) < 3);
        end
        while (plan_missing.size() != 0);
        add_request(csrg_pkg::KIND_GROW, c, r, make_color(-1),
                    $urandom_range(99) < 3);
    endfunction

    function automatic int nearby(int v, int top);
        int t;
        t = v + int'($urandom_range(4)) - 2;
        if (t < 0)
            t = 0;
        if (t > top)
            t = top;
        return t;
    endfunction

    // Mostly well-formed sequences: paint a small patch, grow from a seed near it
    // and read the mask near the seed or anywhere. The rest is noise: stray loads,
    // reads anywhere, unused kinds and grows from arbitrary seeds.
    function automatic void fill_phase(int target);
        int first, ox, oy, w, h, sx, sy, nreads;
        first = planned_items;
        while (planned_items - first < target)
        begin
            if ($urandom_range(99) < 80)
            begin
                ox = $urandom_range(IMG_W - 1);
                oy = $urandom_range(IMG_H - 1);
                w = $urandom_range(5, 1);
                h = $urandom_range(5, 1);
                for (int y = oy; y < oy + h && y < IMG_H; y++)
                    for (int x = ox; x < ox + w && x < IMG_W; x++)
                        add_request(csrg_pkg::KIND_LOAD, x, y, make_color(70),
                                    $urandom_range(99) < 3);
                sx = nearby(ox + 1, IMG_W - 1);
                sy = nearby(oy + 1, IMG_H - 1);
                add_grow(sx, sy, 10);
                nreads = $urandom_range(4, 1);
                repeat (nreads)
                begin
                    if ($urandom_range(1) == 0)
                        add_request(csrg_pkg::KIND_READ, nearby(sx, IMG_W - 1),
                                    nearby(sy, IMG_H - 1), make_color(-1),
                                    $urandom_range(99) < 3);
                    else
                        add_request(csrg_pkg::KIND_READ, $urandom_range(IMG_W - 1),
                                    $urandom_range(IMG_H - 1), make_color(-1),
                                    $urandom_range(99) < 3);
                end
            end
            else
            begin
                sx = $urandom_range(IMG_W - 1);
                sy = $urandom_range(IMG_H - 1);
                case ($urandom_range(3))
                    0: add_request(csrg_pkg::KIND_LOAD, sx, sy, make_color(-1), 1'b0);
                    1: add_request(csrg_pkg::KIND_READ, sx, sy, make_color(-1), 1'b0);
                    2: add_request(KIND_SPARE, sx, sy, make_color(-1), 1'b0);
                    default: add_grow(sx, sy, 5);
                endcase
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. A request stays on the ports until the block takes it
    // (start high and busy low at a rising edge). The next one goes out at
    // the same edge unless the sender idles, or the request is marked to wait
    // until every outstanding result has come back.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit accepted;
        bit launch;
        accepted = start && !busy;
        launch = 1'b0;
        if (accepted)
            apply_request(cur_req);
        if (start && !accepted)
            launch = 1'b1;
        else if (rst_n && request_q.size() != 0 &&
                 $urandom_range(99) >= idle_pct &&
                 (!request_q[0].drain_first || pending_results.size() == 0))
        begin
            cur_req = request_q.pop_front();
            launch = 1'b1;
            kind  <= cur_req.kind;
            col   <= cur_req.col;
            row   <= cur_req.row;
            blue  <= cur_req.color.blue;
            green <= cur_req.color.green;
            red   <= cur_req.color.red;
        end
        start <= launch;
    end

    // ------------------------------------------------------------------------
    // Result monitor. Every done strobe is matched against the oldest
    // predicted result, one field at a time.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done !== 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d size %0d",
                         $time, result_kind, region_size);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_kind !== want.result_kind)
                begin
                    $display("%0t: result_kind expected %0d actual %0d",
                             $time, want.result_kind, result_kind);
                    mismatch_count++;
                end
                if (in_region !== want.in_region)
                begin
                    $display("%0t: in_region expected %0d actual %0d",
                             $time, want.in_region, in_region);
                    mismatch_count++;
                end
                if (region_size !== want.region_size)
                begin
                    $display("%0t: region_size expected %0d actual %0d",
                             $time, want.region_size, region_size);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_budget)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Configuration and sequencing.
    // ------------------------------------------------------------------------

    // One APB write: setup cycle, then access cycle. pready is tied high, so
    // the register takes the value at the edge that ends the access cycle.
    task automatic write_limit(csrg_pkg::reg_idx_t idx, logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            csrg_pkg::REG_BLUE_LIMIT:  lim.blue_limit  = value;
            csrg_pkg::REG_GREEN_LIMIT: lim.green_limit = value;
            default:                   lim.red_limit   = value;
        endcase
        cycle_budget += 20;
    endtask

    // Waits until every queued request has been taken and answered. Loads
    // give no result, so it then waits on a little longer to let the last one land.
    task automatic settle();
        while (request_q.size() != 0 || start || pending_results.size() != 0 ||
               busy !== 1'b0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_limits(int b, int g, int r);
        write_limit(csrg_pkg::REG_BLUE_LIMIT, 8'(b));
        write_limit(csrg_pkg::REG_GREEN_LIMIT, 8'(g));
        write_limit(csrg_pkg::REG_RED_LIMIT, 8'(r));
    endtask

    initial
    begin
        pixel_t pass_px;
        pixel_t fail_px;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset limits (blue < 60, green > 50,
        // red > 150). A read before any grow reports size zero.
        pass_px = '{red: 8'd255, green: 8'd255, blue: 8'd0};
        fail_px = '{red: 8'd255, green: 8'd255, blue: 8'd255};
        add_request(csrg_pkg::KIND_READ, 5, 5, fail_px, 1'b0);
        add_request(csrg_pkg::KIND_LOAD, IMG_W - 1, IMG_H - 1, fail_px, 1'b0);
        add_request(csrg_pkg::KIND_LOAD, 0, IMG_H - 1,
                    '{red: 8'd0, green: 8'd0, blue: 8'd0}, 1'b0);
        add_request(csrg_pkg::KIND_LOAD, 0, 0, pass_px, 1'b0);
        // Colors one step inside and exactly on the limits.
        add_request(csrg_pkg::KIND_LOAD, IMG_W - 1, 0,
                    '{red: 8'd151, green: 8'd51, blue: 8'd59}, 1'b0);
        add_request(csrg_pkg::KIND_LOAD, IMG_W - 2, 0,
                    '{red: 8'd151, green: 8'd51, blue: 8'd60}, 1'b0);
        add_request(csrg_pkg::KIND_LOAD, IMG_W - 2, 1,
                    '{red: 8'd151, green: 8'd50, blue: 8'd59}, 1'b0);
        add_request(csrg_pkg::KIND_LOAD, IMG_W - 1, 1,
                    '{red: 8'd150, green: 8'd51, blue: 8'd59}, 1'b0);
        // The unused kind must neither answer nor touch the image.
        add_request(KIND_SPARE, 1, 1, pass_px, 1'b0);
        // A seed that fails the color test still counts as one pixel.
        add_grow(IMG_W - 1, IMG_H - 1, 0);
        add_request(csrg_pkg::KIND_READ, IMG_W - 1, IMG_H - 1, fail_px, 1'b0);
        add_request(csrg_pkg::KIND_READ, IMG_W - 2, IMG_H - 2, fail_px, 1'b0);
        // Spreading from a corner is clipped at both image edges.
        add_grow(0, 0, 0);
        add_request(csrg_pkg::KIND_READ, 1, 1, fail_px, 1'b0);
        add_request(csrg_pkg::KIND_READ, 2, 2, fail_px, 1'b0);
        // The other corner; its neighbors sit just past the limits.
        add_grow(IMG_W - 1, 0, 0);
        add_request(csrg_pkg::KIND_READ, 0, 0, fail_px, 1'b1);
        add_request(csrg_pkg::KIND_READ, IMG_W - 2, 1, fail_px, 1'b0);
        add_grow(0, IMG_H - 1, 0);
        add_request(csrg_pkg::KIND_READ, 0, IMG_H - 1, fail_px, 1'b1);
        settle();

        // Random phases, each with its own limits and sender idling.
        fill_phase(130);
        settle();
        idle_pct = 76;
        set_limits(255, 0, 0);
        fill_phase(105);
        settle();
        idle_pct = 16;
        set_limits(0, 255, 255);
        fill_phase(105);
        settle();
        idle_pct = 0;
        set_limits($urandom_range(255), $urandom_range(255), $urandom_range(255));
        fill_phase(105);
        settle();
        idle_pct = 76;
        set_limits($urandom_range(255, 128), $urandom_range(127),
                   $urandom_range(127));
        fill_phase(105);
        settle();
        idle_pct = 16;
        set_limits(csrg_pkg::BLUE_LIMIT_RST, csrg_pkg::GREEN_LIMIT_RST,
                   csrg_pkg::RED_LIMIT_RST);
        fill_phase(105);
        settle();

        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
